// ----- hdl/rclr_pkg.sv -----
`default_nettype none
package rclr_pkg;

  localparam int unsigned POOL   = 64;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned RANK_W = 6;
  localparam int unsigned CFG_W  = 7;

  localparam logic [1:0] OP_REG_CACHE = 2'd0;
  localparam logic [1:0] OP_REG_PLAIN = 2'd1;
  localparam logic [1:0] OP_UNREG     = 2'd2;

  localparam logic [2:0] ST_HIT          = 3'd0;
  localparam logic [2:0] ST_NEW_CACHED   = 3'd1;
  localparam logic [2:0] ST_NEW_UNCACHED = 3'd2;
  localparam logic [2:0] ST_POOL_EMPTY   = 3'd3;
  localparam logic [2:0] ST_REF_DROPPED  = 3'd4;
  localparam logic [2:0] ST_FREED        = 3'd5;
  localparam logic [2:0] ST_BAD_HANDLE   = 3'd6;

  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_LIMIT  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SDRAIN,
    S_UREAD,
    S_DECIDE,
    S_PASS,
    S_PDRAIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic cnt_clr;
    logic scan_rd;
    logic pass_rd;
    logic use_h;
    logic decide;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic       cnt_last;
    logic [1:0] op;
    logic       need_pass;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- hdl/registration_cache_lru_refcount.sv -----
// Registration cache over a pool of 64 entries with recency order and use counts.
// Each request gives exactly one result. A register request sweeps the entry tables
// one entry per cycle through a single read port; when the recency order changes (a hit
// or a new cached entry) a second sweep rewrites the ranks. An unregister sweeps only
// to rewrite the ranks when it frees a cached entry. One request is in flight at a
// time; a finished result waits in an output register while the next request is
// accepted. Configuration writes must only be made while no request is open.
`default_nettype none
module registration_cache_lru_refcount
  import rclr_pkg::*;
#(
  parameter int unsigned ADDR_BITS  = 48,
  parameter int unsigned LEN_BITS   = 32,
  parameter int unsigned COUNT_BITS = 16,
  localparam int unsigned IN_TW  = ((ADDR_BITS + LEN_BITS + IDX_W + 7) / 8) * 8,
  localparam int unsigned OUT_TW = ((2 * IDX_W + ADDR_BITS + LEN_BITS + 7) / 8) * 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_addr_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [IN_TW-1:0]  s_axis_tdata,  // region_addr, region_len, entry_handle
  input  wire logic [1:0]        s_axis_tuser,  // op
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [OUT_TW-1:0]      m_axis_tdata,  // handle, evict_handle, evict_addr, evict_len
  output logic [3:0]             m_axis_tuser   // status, evict_valid
);

  cmd_t cmd;
  sts_t sts;

  rclr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rclr_dp #(
    .ADDR_BITS  (ADDR_BITS),
    .LEN_BITS   (LEN_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule
`default_nettype wire

// ----- hdl/rclr_ctrl.sv -----
`default_nettype none
module rclr_ctrl
  import rclr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.op inside {OP_REG_CACHE, OP_REG_PLAIN}) begin
            state_d = S_SCAN;
          end else if (sts_i.op == OP_UNREG) begin
            state_d = S_UREAD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (sts_i.cnt_last) begin
          state_d = S_SDRAIN;
        end
      end
      S_SDRAIN: state_d = S_DECIDE;
      S_UREAD:  state_d = S_DECIDE;
      S_DECIDE: begin
        state_d = sts_i.need_pass ? S_PASS : S_DONE;
      end
      S_PASS: begin
        if (sts_i.cnt_last) begin
          state_d = S_PDRAIN;
        end
      end
      S_PDRAIN: state_d = S_DONE;
      S_DONE: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load    = in_valid_i;
        cmd_o.cnt_clr = in_valid_i;
      end
      S_SCAN:  cmd_o.scan_rd = 1'b1;
      S_UREAD: cmd_o.use_h   = 1'b1;
      S_DECIDE: begin
        cmd_o.decide  = 1'b1;
        cmd_o.cnt_clr = 1'b1;
      end
      S_PASS:  cmd_o.pass_rd  = 1'b1;
      S_DONE:  cmd_o.out_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/rclr_dp.sv -----
`default_nettype none
module rclr_dp
  import rclr_pkg::*;
#(
  parameter int unsigned ADDR_BITS  = 48,
  parameter int unsigned LEN_BITS   = 32,
  parameter int unsigned COUNT_BITS = 16,
  localparam int unsigned IN_TW  = ((ADDR_BITS + LEN_BITS + IDX_W + 7) / 8) * 8,
  localparam int unsigned OUT_TW = ((2 * IDX_W + ADDR_BITS + LEN_BITS + 7) / 8) * 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_addr_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  input  wire logic [IN_TW-1:0]  s_axis_tdata,
  input  wire logic [1:0]        s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [OUT_TW-1:0]      m_axis_tdata,
  output logic [3:0]             m_axis_tuser,
  input  wire cmd_t              cmd_i,
  output sts_t                   sts_o
);

  localparam int unsigned E_W = ((ADDR_BITS > LEN_BITS) ? ADDR_BITS : LEN_BITS) + 1;

  // config
  logic             en_q;
  logic [CFG_W-1:0] lim_q;

  // request
  logic [1:0]           op_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [LEN_BITS-1:0]  len_q;
  logic [E_W-1:0]       qend_q;
  logic [IDX_W-1:0]     h_q;
  logic                 use_cache_q;

  // entry state
  logic [POOL-1:0]  busy_q, busy_d, cached_q, cached_d, fs_vld_q;
  logic [CNT_W-1:0] fc_q, fc_d, cc_q, cc_d;

  logic [ADDR_BITS-1:0]  start_mem [POOL];
  logic [LEN_BITS-1:0]   len_mem   [POOL];
  logic [E_W-1:0]        end_mem   [POOL];
  logic [COUNT_BITS-1:0] use_mem   [POOL];
  logic [RANK_W-1:0]     rank_mem  [POOL];
  logic [IDX_W-1:0]      fs_mem    [POOL];

  logic [ADDR_BITS-1:0]  start_rd_q;
  logic [LEN_BITS-1:0]   len_rd_q;
  logic [E_W-1:0]        end_rd_q;
  logic [COUNT_BITS-1:0] use_rd_q;
  logic [RANK_W-1:0]     rank_rd_q;
  logic [IDX_W-1:0]      fs_rd_q, fs_rslot_q;

  logic [IDX_W-1:0] cnt_q, rd_addr, fs_ra, stg_idx_q, pop_e;
  logic             stg_scan_q, stg_pass_q;

  // scan captures
  logic                  hit_q, lru_found_q;
  logic [IDX_W-1:0]      best_q, lru_q;
  logic [RANK_W-1:0]     best_rank_q;
  logic [COUNT_BITS-1:0] best_use_q, lru_use_q;
  logic [ADDR_BITS-1:0]  lru_start_q;
  logic [LEN_BITS-1:0]   lru_len_q;

  // pass control
  logic             pinc_q, pinc_d;
  logic [IDX_W-1:0] ptgt_q, ptgt_d;
  logic [CNT_W-1:0] pthr_q, pthr_d;

  // result
  logic [IDX_W-1:0]     res_h_q, res_h_d, res_evh_q, res_evh_d;
  logic [2:0]           res_st_q, res_st_d;
  logic                 res_ev_q, res_ev_d;
  logic [ADDR_BITS-1:0] res_eva_q, res_eva_d;
  logic [LEN_BITS-1:0]  res_evl_q, res_evl_d;

  logic                 out_vld_q;
  logic [IDX_W-1:0]     out_h_q, out_evh_q;
  logic [2:0]           out_st_q;
  logic                 out_ev_q;
  logic [ADDR_BITS-1:0] out_eva_q;
  logic [LEN_BITS-1:0]  out_evl_q;

  // memory write controls
  logic                  ent_we, use_we, fs_we, rank_we, need_pass;
  logic [IDX_W-1:0]      use_wa, fs_wa, fs_wd;
  logic [COUNT_BITS-1:0] use_wd;
  logic [RANK_W-1:0]     rank_wd;

  logic             hit_i, better_i, lru_i, room0, evict, room;
  logic [CNT_W-1:0] cc_ev, rk_ext;

  logic [ADDR_BITS-1:0] in_addr;
  logic [LEN_BITS-1:0]  in_len;
  logic [IDX_W-1:0]     in_h;

  assign in_addr = s_axis_tdata[ADDR_BITS-1:0];
  assign in_len  = s_axis_tdata[ADDR_BITS +: LEN_BITS];
  assign in_h    = s_axis_tdata[ADDR_BITS+LEN_BITS +: IDX_W];

  assign rd_addr = cmd_i.use_h ? h_q : cnt_q;
  assign fs_ra   = fc_q[IDX_W-1:0] - IDX_W'(1);
  assign pop_e   = fs_vld_q[fs_rslot_q] ? fs_rd_q : (IDX_W'(POOL - 1) - fs_rslot_q);
  assign rk_ext  = {1'b0, rank_rd_q};

  assign sts_o.cnt_last  = (cnt_q == IDX_W'(POOL - 1));
  assign sts_o.op        = s_axis_tuser;
  assign sts_o.need_pass = need_pass;
  assign sts_o.out_free  = !out_vld_q || m_axis_tready;

  // lookup compare on registered entry data
  assign hit_i    = use_cache_q && busy_q[stg_idx_q] && cached_q[stg_idx_q]
                    && (E_W'(addr_q) >= E_W'(start_rd_q)) && (qend_q <= end_rd_q);
  assign better_i = hit_i && (!hit_q || (rank_rd_q < best_rank_q));
  assign lru_i    = cached_q[stg_idx_q] && (rk_ext == (cc_q - CNT_W'(1)));

  // recency update during the pass
  always_comb begin
    rank_we = 1'b0;
    rank_wd = rank_rd_q;
    if (stg_pass_q) begin
      if (pinc_q) begin
        if (stg_idx_q == ptgt_q) begin
          rank_we = 1'b1;
          rank_wd = '0;
        end else if (cached_q[stg_idx_q] && (rk_ext < pthr_q)) begin
          rank_we = 1'b1;
          rank_wd = rank_rd_q + RANK_W'(1);
        end
      end else if (cached_q[stg_idx_q] && (stg_idx_q != ptgt_q) && (rk_ext > pthr_q)) begin
        rank_we = 1'b1;
        rank_wd = rank_rd_q - RANK_W'(1);
      end
    end
  end

  assign room0 = cc_q < lim_q;
  assign evict = use_cache_q && !room0 && (cc_q != '0) && lru_found_q && (lru_use_q == '0);
  assign cc_ev = cc_q - CNT_W'(evict);
  assign room  = cc_ev < lim_q;

  always_comb begin
    busy_d    = busy_q;
    cached_d  = cached_q;
    fc_d      = fc_q;
    cc_d      = cc_q;
    ent_we    = 1'b0;
    use_we    = 1'b0;
    use_wa    = h_q;
    use_wd    = '0;
    fs_we     = 1'b0;
    fs_wa     = fs_rslot_q;
    fs_wd     = h_q;
    need_pass = 1'b0;
    pinc_d    = pinc_q;
    ptgt_d    = ptgt_q;
    pthr_d    = pthr_q;
    res_h_d   = res_h_q;
    res_st_d  = res_st_q;
    res_ev_d  = res_ev_q;
    res_evh_d = res_evh_q;
    res_eva_d = res_eva_q;
    res_evl_d = res_evl_q;
    if (cmd_i.load) begin
      res_h_d   = in_h;
      res_st_d  = ST_BAD_HANDLE;
      res_ev_d  = 1'b0;
      res_evh_d = '0;
      res_eva_d = '0;
      res_evl_d = '0;
    end else if (cmd_i.decide) begin
      if (op_q == OP_UNREG) begin
        res_h_d = h_q;
        if (!busy_q[h_q]) begin
          res_st_d = ST_BAD_HANDLE;
        end else if (cached_q[h_q] && en_q) begin
          use_we   = 1'b1;
          use_wd   = (use_rd_q == '0) ? '0 : use_rd_q - COUNT_BITS'(1);
          res_st_d = ST_REF_DROPPED;
        end else begin
          if (cached_q[h_q]) begin
            cached_d[h_q] = 1'b0;
            if (cc_q != '0) begin
              cc_d = cc_q - CNT_W'(1);
            end
            need_pass = 1'b1;
            pinc_d    = 1'b0;
            ptgt_d    = h_q;
            pthr_d    = rk_ext;
          end
          busy_d[h_q] = 1'b0;
          if (fc_q < CNT_W'(POOL)) begin
            fs_we = 1'b1;
            fs_wa = fc_q[IDX_W-1:0];
            fs_wd = h_q;
            fc_d  = fc_q + CNT_W'(1);
          end
          res_st_d = ST_FREED;
        end
      end else if (hit_q) begin
        use_we    = 1'b1;
        use_wa    = best_q;
        use_wd    = (best_use_q == '1) ? best_use_q : best_use_q + COUNT_BITS'(1);
        res_h_d   = best_q;
        res_st_d  = ST_HIT;
        need_pass = 1'b1;
        pinc_d    = 1'b1;
        ptgt_d    = best_q;
        pthr_d    = {1'b0, best_rank_q};
      end else if (fc_q == '0) begin
        res_h_d  = '0;
        res_st_d = ST_POOL_EMPTY;
      end else begin
        fc_d            = fc_q - CNT_W'(1);
        busy_d[pop_e]   = 1'b1;
        cached_d[pop_e] = 1'b0;
        ent_we          = 1'b1;
        use_we          = 1'b1;
        use_wa          = pop_e;
        use_wd          = '0;
        res_h_d         = pop_e;
        res_st_d        = ST_NEW_UNCACHED;
        if (evict) begin
          cached_d[lru_q] = 1'b0;
          busy_d[lru_q]   = 1'b0;
          fs_we           = 1'b1;
          fs_wa           = fs_rslot_q;
          fs_wd           = lru_q;
          fc_d            = fc_q;
          cc_d            = cc_ev;
          res_ev_d        = 1'b1;
          res_evh_d       = lru_q;
          res_eva_d       = lru_start_q;
          res_evl_d       = lru_len_q;
        end
        if (use_cache_q && room) begin
          cached_d[pop_e] = 1'b1;
          use_wd          = COUNT_BITS'(1);
          cc_d            = cc_ev + CNT_W'(1);
          res_st_d        = ST_NEW_CACHED;
          need_pass       = 1'b1;
          pinc_d          = 1'b1;
          ptgt_d          = pop_e;
          pthr_d          = '1;
        end
      end
    end
  end

  // entry tables
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      start_mem[pop_e] <= addr_q;
      len_mem[pop_e]   <= len_q;
      end_mem[pop_e]   <= qend_q;
    end
    if (use_we) begin
      use_mem[use_wa] <= use_wd;
    end
    if (rank_we) begin
      rank_mem[stg_idx_q] <= rank_wd;
    end
    if (fs_we) begin
      fs_mem[fs_wa] <= fs_wd;
    end
    start_rd_q <= start_mem[rd_addr];
    len_rd_q   <= len_mem[rd_addr];
    end_rd_q   <= end_mem[rd_addr];
    use_rd_q   <= use_mem[rd_addr];
    rank_rd_q  <= rank_mem[rd_addr];
    fs_rd_q    <= fs_mem[fs_ra];
    fs_rslot_q <= fs_ra;
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q        <= s_axis_tuser;
      addr_q      <= in_addr;
      len_q       <= in_len;
      h_q         <= in_h;
      qend_q      <= E_W'(in_addr) + E_W'(in_len);
      use_cache_q <= (s_axis_tuser == OP_REG_CACHE) && en_q;
    end
    if (stg_scan_q) begin
      if (better_i) begin
        best_q      <= stg_idx_q;
        best_rank_q <= rank_rd_q;
        best_use_q  <= use_rd_q;
      end
      if (lru_i) begin
        lru_q       <= stg_idx_q;
        lru_use_q   <= use_rd_q;
        lru_start_q <= start_rd_q;
        lru_len_q   <= len_rd_q;
      end
    end
    pinc_q    <= pinc_d;
    ptgt_q    <= ptgt_d;
    pthr_q    <= pthr_d;
    res_h_q   <= res_h_d;
    res_st_q  <= res_st_d;
    res_ev_q  <= res_ev_d;
    res_evh_q <= res_evh_d;
    res_eva_q <= res_eva_d;
    res_evl_q <= res_evl_d;
    if (cmd_i.out_load) begin
      out_h_q   <= res_h_q;
      out_st_q  <= res_st_q;
      out_ev_q  <= res_ev_q;
      out_evh_q <= res_evh_q;
      out_eva_q <= res_eva_q;
      out_evl_q <= res_evl_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= 1'b1;
      lim_q       <= CFG_W'(32);
      busy_q      <= '0;
      cached_q    <= '0;
      fs_vld_q    <= '0;
      fc_q        <= CNT_W'(POOL);
      cc_q        <= '0;
      cnt_q       <= '0;
      stg_scan_q  <= 1'b0;
      stg_pass_q  <= 1'b0;
      stg_idx_q   <= '0;
      hit_q       <= 1'b0;
      lru_found_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == CFG_ENABLE) begin
          en_q <= cfg_wdata_i[0];
        end else begin
          lim_q <= cfg_wdata_i;
        end
      end
      busy_q   <= busy_d;
      cached_q <= cached_d;
      fc_q     <= fc_d;
      cc_q     <= cc_d;
      if (fs_we) begin
        fs_vld_q[fs_wa] <= 1'b1;
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.scan_rd || cmd_i.pass_rd) begin
        cnt_q <= cnt_q + IDX_W'(1);
      end
      stg_scan_q <= cmd_i.scan_rd;
      stg_pass_q <= cmd_i.pass_rd;
      stg_idx_q  <= cnt_q;
      if (cmd_i.load) begin
        hit_q       <= 1'b0;
        lru_found_q <= 1'b0;
      end else if (stg_scan_q) begin
        hit_q       <= hit_q || hit_i;
        lru_found_q <= lru_found_q || lru_i;
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = {out_ev_q, out_st_q};
  assign m_axis_tdata  = OUT_TW'({out_evl_q, out_eva_q, out_evh_q, out_h_q});

endmodule
`default_nettype wire
